// ----- rtl/core/avad_pkg.sv -----
// Shared types, register map and constants for the adaptive voice activity detector.
// Used by adaptive_voice_activity_detector; depends on nothing.
`default_nettype none

package avad_pkg;

  // Register file layout
  localparam int unsigned CFG_NUM   = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W     = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_AVG_FLOOR  = 3'd0,
    CFG_START_PEAK_LEVEL = 3'd1,
    CFG_STOP_AVG_FLOOR   = 3'd2,
    CFG_START_MARGIN     = 3'd3,
    CFG_STOP_MARGIN      = 3'd4,
    CFG_TAIL_MS          = 3'd5,
    CFG_MIN_SPEECH_MS    = 3'd6,
    CFG_MAX_SPEECH_MS    = 3'd7
  } cfg_idx_e;

  localparam logic [CFG_W-1:0] CFG_RESET [CFG_NUM] = '{
    16'd520, 16'd2600, 16'd260, 16'd380, 16'd170, 16'd950, 16'd320, 16'd12000
  };

  // Noise floor bounds
  localparam int unsigned FLOOR_W = 9;
  localparam logic [FLOOR_W-1:0] FLOOR_MIN = 9'd60;
  localparam logic [FLOOR_W-1:0] FLOOR_MAX = 9'd460;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_DIV    = 2'd1,
    ST_THR    = 2'd2,
    ST_DETECT = 2'd3
  } state_e;

  // Input transaction
  typedef struct packed {
    logic signed [15:0] sample;
    logic               chunk_last;
    logic [31:0]        now_ms;
    logic               gate_open;
    logic               busy_release;
  } in_t;

  // Result transaction
  typedef struct packed {
    logic [15:0]        chunk_peak;
    logic [15:0]        chunk_average;
    logic [FLOOR_W-1:0] noise_level;
    logic               speaking;
    logic               forward_chunk;
    logic               utterance_start;
    logic               utterance_end;
    logic               end_reason;
  } out_t;

  // Clamp a level into the noise floor range
  function automatic logic [FLOOR_W-1:0] clamp_floor(input logic [15:0] v);
    logic [FLOOR_W-1:0] r;
    if (v < 16'(FLOOR_MIN)) begin
      r = FLOOR_MIN;
    end else if (v > 16'(FLOOR_MAX)) begin
      r = FLOOR_MAX;
    end else begin
      r = v[FLOOR_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/avad_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
// Used by adaptive_voice_activity_detector; no package dependencies.
`default_nettype none

module avad_div #(
  parameter int unsigned DIVIDEND_W = 28,
  parameter int unsigned DIVISOR_W  = 13
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [DIVIDEND_W-1:0] dividend_i,
  input  wire logic [DIVISOR_W-1:0]  divisor_i,
  output logic                       done_o,
  output logic [DIVIDEND_W-1:0]      quot_o
);

  localparam int unsigned STEP_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [STEP_W-1:0]     step_q, step_d;
  logic [DIVIDEND_W-1:0] quot_q, quot_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVISOR_W-1:0]  dvs_q, dvs_d;
  logic [DIVISOR_W:0]    trial;

  // One shift-subtract step per cycle
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    step_d = step_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    trial  = {rem_q, quot_q[DIVIDEND_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d  = DIVISOR_W'(trial - {1'b0, dvs_q});
        quot_d = {quot_q[DIVIDEND_W-2:0], 1'b1};
      end else begin
        rem_d  = trial[DIVISOR_W-1:0];
        quot_d = {quot_q[DIVIDEND_W-2:0], 1'b0};
      end
      if (step_q == STEP_W'(DIVIDEND_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // Datapath, no reset needed
  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

// ----- rtl/core/adaptive_voice_activity_detector.sv -----
// Adaptive voice activity detector: chunk level measurement and speech detection.
// Depends on avad_pkg and avad_div.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one PCM sample per
//   transaction with chunk_last, now_ms, gate_open and busy_release. Output channel
//   (out_valid_o / out_stall_i / out_data_o) carries one result per chunk, issued
//   for the transaction that has chunk_last set; other samples give no result.
//   Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i at once;
//   write only while the block is idle.
// Sequence:
//   A sample without chunk_last is taken while the block is idle and leaves it idle. A
//   chunk end passes through acceptance, the serial divider, a step for thresholds and
//   elapsed times and a step for the decision; in_stall_o is high after acceptance
//   until the decision commits its result to the output register.
// Stalls:
//   The result sits in an output register; new samples are taken while it waits.
//   A following chunk end holds in its decision step until the register frees.
// Reset:
//   Registers return to their defaults, noise floor to NOISE_FLOOR_INIT, all
//   accumulators and detector state clear; the block is ready straight away.
`default_nettype none

module adaptive_voice_activity_detector #(
  parameter int unsigned MAX_CHUNK_SAMPLES  = 4096,
  parameter int unsigned START_HITS_NEEDED  = 2,
  parameter int unsigned SILENCE_HITS_GRACE = 4,
  parameter int unsigned REARM_DELAY_MS     = 900,
  parameter int unsigned NOISE_FLOOR_INIT   = 140
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [avad_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [avad_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire avad_pkg::in_t                 in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output avad_pkg::out_t                     out_data_o
);

  localparam int unsigned CNT_W   = $clog2(MAX_CHUNK_SAMPLES + 1);
  localparam int unsigned SUM_W   = CNT_W + 15;
  localparam int unsigned SHIT_W  = $clog2(START_HITS_NEEDED + 1);
  localparam int unsigned QHIT_W  = $clog2(SILENCE_HITS_GRACE + 1);
  localparam int unsigned FLOOR_W = avad_pkg::FLOOR_W;

  // Configuration registers
  logic [avad_pkg::CFG_W-1:0] cfg_q [avad_pkg::CFG_NUM];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < avad_pkg::CFG_NUM; i++) begin
        cfg_q[i] <= avad_pkg::CFG_RESET[i];
      end
    end else if (cfg_we_i) begin
      cfg_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  logic [15:0] start_avg_floor, start_peak_level, stop_avg_floor, start_margin;
  logic [15:0] stop_margin, tail_ms, min_speech_ms, max_speech_ms;
  assign start_avg_floor  = cfg_q[avad_pkg::CFG_START_AVG_FLOOR];
  assign start_peak_level = cfg_q[avad_pkg::CFG_START_PEAK_LEVEL];
  assign stop_avg_floor   = cfg_q[avad_pkg::CFG_STOP_AVG_FLOOR];
  assign start_margin     = cfg_q[avad_pkg::CFG_START_MARGIN];
  assign stop_margin      = cfg_q[avad_pkg::CFG_STOP_MARGIN];
  assign tail_ms          = cfg_q[avad_pkg::CFG_TAIL_MS];
  assign min_speech_ms    = cfg_q[avad_pkg::CFG_MIN_SPEECH_MS];
  assign max_speech_ms    = cfg_q[avad_pkg::CFG_MAX_SPEECH_MS];

  // State
  avad_pkg::state_e state_q, state_d;

  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [15:0]        peak_q, peak_d;
  logic [FLOOR_W-1:0] floor_q, floor_d;
  logic [SHIT_W-1:0]  shits_q, shits_d;
  logic [QHIT_W-1:0]  qhits_q, qhits_d;
  logic               speech_q, speech_d;
  logic               await_q, await_d;
  logic [31:0]        rearm_q, rearm_d;
  logic [31:0]        begin_q, begin_d;
  logic [31:0]        voice_q, voice_d;

  // Latched chunk-end inputs and intermediate results
  logic [31:0]        now_q, now_d;
  logic               gate_q, gate_d;
  logic [15:0]        avg_q, avg_d;
  logic [16:0]        sthr_q, sthr_d;
  logic [16:0]        pthr_q, pthr_d;
  logic [FLOOR_W-1:0] fcand_q, fcand_d;
  logic               ok_q, ok_d;
  logic               peak_ge_q, peak_ge_d;
  logic               sp_max_q, sp_max_d;
  logic               sp_min_q, sp_min_d;
  logic               tail_q, tail_d;

  logic               out_valid_q, out_valid_d;
  avad_pkg::out_t     out_q, out_d;

  logic               in_acc;
  logic               div_start, div_done;
  logic [SUM_W-1:0]   quot;
  logic               commit;
  logic [15:0]        mag;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign div_start = in_acc && in_data_i.chunk_last;
  assign commit    = (state_q == avad_pkg::ST_DETECT) && !(out_valid_q && out_stall_i);
  assign mag       = in_data_i.sample[15] ? (~in_data_i.sample + 16'd1) : in_data_i.sample;

  // Mean level: serial divider
  avad_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_d),
    .divisor_i  (cnt_d),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      avad_pkg::ST_IDLE:   if (div_start) state_d = avad_pkg::ST_DIV;
      avad_pkg::ST_DIV:    if (div_done) state_d = avad_pkg::ST_THR;
      avad_pkg::ST_THR:    state_d = avad_pkg::ST_DETECT;
      avad_pkg::ST_DETECT: if (commit) state_d = avad_pkg::ST_IDLE;
      default:             state_d = avad_pkg::ST_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != avad_pkg::ST_IDLE);

  // Datapath and detector
  always_comb begin
    logic [16:0]        sum_start, sum_stop;
    logic [FLOOR_W-1:0] s_lvl;
    logic [12:0]        mix;
    logic [31:0]        sp_ms, sl_ms;
    logic               ge_start, ge_stop, hit, go, began, ended, by_max, lv_upd;
    logic               min_ok, max_ok, tail_ok;

    sum_d     = sum_q;
    cnt_d     = cnt_q;
    peak_d    = peak_q;
    floor_d   = floor_q;
    shits_d   = shits_q;
    qhits_d   = qhits_q;
    speech_d  = speech_q;
    await_d   = await_q;
    rearm_d   = rearm_q;
    begin_d   = begin_q;
    voice_d   = voice_q;
    now_d     = now_q;
    gate_d    = gate_q;
    avg_d     = avg_q;
    sthr_d    = sthr_q;
    pthr_d    = pthr_q;
    fcand_d   = fcand_q;
    ok_d      = ok_q;
    peak_ge_d = peak_ge_q;
    sp_max_d  = sp_max_q;
    sp_min_d  = sp_min_q;
    tail_d    = tail_q;
    out_d     = out_q;

    sum_start = {8'd0, floor_q} + {1'b0, start_margin};
    sum_stop  = {8'd0, floor_q} + {1'b0, stop_margin};
    s_lvl     = '0;
    mix       = '0;
    sp_ms     = now_q - begin_q;
    sl_ms     = now_q - voice_q;
    ge_start  = ({1'b0, avg_q} >= sthr_q);
    ge_stop   = ({1'b0, avg_q} >= pthr_q);
    hit       = 1'b0;
    go        = 1'b0;
    began     = 1'b0;
    ended     = 1'b0;
    by_max    = 1'b0;
    lv_upd    = 1'b0;
    min_ok    = 1'b0;
    max_ok    = 1'b0;
    tail_ok   = 1'b0;

    // Per-sample accumulation, release handling at acceptance
    if (in_acc) begin
      if (in_data_i.busy_release) begin
        await_d = 1'b0;
        rearm_d = in_data_i.now_ms + 32'(REARM_DELAY_MS);
        shits_d = '0;
        qhits_d = '0;
      end
      if (cnt_q < CNT_W'(MAX_CHUNK_SAMPLES)) begin
        sum_d = sum_q + SUM_W'(mag);
        cnt_d = cnt_q + 1'b1;
        if (mag > peak_q) peak_d = mag;
      end
      now_d  = in_data_i.now_ms;
      gate_d = in_data_i.gate_open;
    end

    // Mean ready: thresholds, floor candidate, elapsed-time flags
    if (state_q == avad_pkg::ST_THR) begin
      avg_d     = (cnt_q == '0) ? 16'd0 : quot[15:0];
      s_lvl     = avad_pkg::clamp_floor(avg_d);
      mix       = ({floor_q, 4'd0} - {4'd0, floor_q}) + {4'd0, s_lvl};
      fcand_d   = avad_pkg::clamp_floor({7'd0, mix[12:4]});
      sthr_d    = (sum_start > {1'b0, start_avg_floor}) ? sum_start : {1'b0, start_avg_floor};
      pthr_d    = (sum_stop > {1'b0, stop_avg_floor}) ? sum_stop : {1'b0, stop_avg_floor};
      ok_d      = gate_q && !await_q && (now_q >= rearm_q);
      peak_ge_d = (peak_q >= start_peak_level);
      sp_max_d  = (sp_ms >= {16'd0, max_speech_ms});
      sp_min_d  = (sp_ms >= {16'd0, min_speech_ms});
      tail_d    = (sl_ms >= {16'd0, tail_ms});
    end

    // Detector decision and result
    if (commit) begin
      if (ok_q) begin
        go = 1'b1;
        if (!speech_q) begin
          hit = ge_start || (peak_ge_q && ge_stop);
          if (hit) begin
            if (shits_q < SHIT_W'(START_HITS_NEEDED)) shits_d = shits_q + 1'b1;
          end else begin
            if (!ge_start) floor_d = fcand_q;
            if (shits_q != '0) shits_d = shits_q - 1'b1;
          end
          if (shits_d < SHIT_W'(START_HITS_NEEDED)) begin
            go = 1'b0;
          end else begin
            speech_d = 1'b1;
            began    = 1'b1;
            begin_d  = now_q;
            voice_d  = now_q;
            qhits_d  = '0;
          end
        end
        if (go) begin
          if (ge_stop) begin
            qhits_d = '0;
            lv_upd  = 1'b1;
          end else begin
            if (qhits_d < QHIT_W'(SILENCE_HITS_GRACE)) qhits_d = qhits_d + 1'b1;
            if (qhits_d < QHIT_W'(SILENCE_HITS_GRACE)) lv_upd = 1'b1;
          end
          if (lv_upd) voice_d = now_q;
          // A fresh start has zero elapsed speech time
          min_ok  = began ? (min_speech_ms == 16'd0) : sp_min_q;
          max_ok  = began ? (max_speech_ms == 16'd0) : sp_max_q;
          tail_ok = (began || lv_upd) ? (tail_ms == 16'd0) : tail_q;
          if ((min_ok && tail_ok) || max_ok) begin
            ended    = 1'b1;
            by_max   = max_ok;
            speech_d = 1'b0;
            shits_d  = '0;
            qhits_d  = '0;
            await_d  = 1'b1;
            rearm_d  = now_q + 32'(REARM_DELAY_MS);
          end
        end
      end
      out_d.chunk_peak      = peak_q;
      out_d.chunk_average   = avg_q;
      out_d.noise_level     = floor_d;
      out_d.speaking        = speech_d;
      out_d.forward_chunk   = go;
      out_d.utterance_start = began;
      out_d.utterance_end   = ended;
      out_d.end_reason      = by_max;
      sum_d  = '0;
      cnt_d  = '0;
      peak_d = '0;
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= avad_pkg::ST_IDLE;
      sum_q       <= '0;
      cnt_q       <= '0;
      peak_q      <= '0;
      floor_q     <= FLOOR_W'(NOISE_FLOOR_INIT);
      shits_q     <= '0;
      qhits_q     <= '0;
      speech_q    <= 1'b0;
      await_q     <= 1'b0;
      rearm_q     <= '0;
      begin_q     <= '0;
      voice_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      peak_q      <= peak_d;
      floor_q     <= floor_d;
      shits_q     <= shits_d;
      qhits_q     <= qhits_d;
      speech_q    <= speech_d;
      await_q     <= await_d;
      rearm_q     <= rearm_d;
      begin_q     <= begin_d;
      voice_q     <= voice_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    now_q     <= now_d;
    gate_q    <= gate_d;
    avg_q     <= avg_d;
    sthr_q    <= sthr_d;
    pthr_q    <= pthr_d;
    fcand_q   <= fcand_d;
    ok_q      <= ok_d;
    peak_ge_q <= peak_ge_d;
    sp_max_q  <= sp_max_d;
    sp_min_q  <= sp_min_d;
    tail_q    <= tail_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  a_rise_from_detect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == avad_pkg::ST_DETECT))
    else $error("result issued outside the decision step");

  a_start_hits_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shits_q <= SHIT_W'(START_HITS_NEEDED))
    else $error("start hit count above limit");

  a_silence_hits_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qhits_q <= QHIT_W'(SILENCE_HITS_GRACE))
    else $error("silence hit count above limit");

  a_floor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (floor_q >= avad_pkg::FLOOR_MIN) && (floor_q <= avad_pkg::FLOOR_MAX))
    else $error("noise floor out of range");

  a_end_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((!out_q.end_reason || out_q.utterance_end) &&
                     (!out_q.utterance_end || out_q.forward_chunk)))
    else $error("inconsistent end flags");

  a_end_clears_speech: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) && out_q.utterance_end |-> !speech_q && await_q)
    else $error("end did not drop speech or set release wait");

endmodule

`default_nettype wire
